FILE: sv/crlvg_pkg.sv
// ----------------------------------------------------------------------------
// crlvg_pkg
// Shared widths, constants, register indexes and controller/datapath bundles
// for the chunked RMS level meter with voice gate.
// ----------------------------------------------------------------------------
package crlvg_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned CHUNK_SAMPLES_DEF = 50;
  localparam int unsigned HOLD_MS_DEF       = 50;

  // Fixed field widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Per-sample arithmetic widths (bounded by value, not by product size)
  localparam int unsigned MAG_W   = SAMPLE_W + 1;  // |sample| up to 32768
  localparam int unsigned USQ_W   = 31;            // mag^2 up to 2^30
  localparam int unsigned GPROD_W = 31;            // mag*gain below 2^31
  localparam int unsigned GMAG_W  = 19;            // rounded gained magnitude
  localparam int unsigned GSQ_W   = 2 * GMAG_W;    // gained square

  // log2 unit: Q30 mantissa, 16 fraction bits
  localparam int unsigned MANT_W = 31;
  localparam int unsigned FRAC_W = 16;

  // Gain is Q4.12
  localparam int unsigned GAIN_SHIFT = 12;
  localparam int unsigned GAIN_HALF  = 2048;

  // dB conversion: level = round(L * DB_PER_LOG2 / 2^24) - FULL_SCALE_DB
  localparam int unsigned DB_PER_LOG2   = 197283;
  localparam int unsigned DB_K_W        = 19;      // signed width of DB_PER_LOG2
  localparam int unsigned ROUND_SHIFT   = 24;
  localparam int unsigned FULL_SCALE_DB = 23119;

  localparam logic signed [LEVEL_W-1:0] FLOOR_DB     = -16'sd32512;  // -127 dB
  localparam logic        [GAIN_W-1:0]  GAIN_RESET   = 16'd4096;     // unity
  localparam logic signed [LEVEL_W-1:0] THRESH_RESET = -16'sd10240;  // -40 dB

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_GAIN   = 2'd0,
    CFG_THRESHOLD_DB = 2'd1,
    CFG_VOICE_MODE   = 2'd2
  } cfg_reg_e;

  // Operand of the shared log2 unit
  typedef enum logic [1:0] {
    OP_COUNT  = 2'd0,
    OP_UNITY  = 2'd1,
    OP_GAINED = 2'd2
  } log_op_e;

  typedef struct packed {
    logic    load_in;
    logic    square;
    logic    gain_square;
    logic    accumulate;
    logic    log_start;
    log_op_e log_sel;
    logic    latch_ln;
    logic    scale;
    logic    round;
    logic    peak_update;
    logic    clear_chunk;
    logic    emit;
  } dp_cmd_t;

  typedef struct packed {
    logic close_chunk;
    logic buffer_end;
    logic log_done;
    logic out_free;
  } dp_status_t;

endpackage

FILE: sv/crlvg_log2.sv
// ----------------------------------------------------------------------------
// crlvg_log2
// Iterative log2 in Q16: leading-zero search by halving steps, then one
// mantissa squaring per cycle for each fraction bit.
// ----------------------------------------------------------------------------
module crlvg_log2 import crlvg_pkg::*; #(
  parameter int unsigned OPER_W = 44
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [OPER_W-1:0]                    oper_i,
  output logic                                 done_o,
  output logic [$clog2(OPER_W)+FRAC_W-1:0]     log_o
);

  localparam int unsigned EXP_W      = $clog2(OPER_W);
  localparam int unsigned NORM_STEPS = EXP_W;
  localparam int unsigned STEPS      = NORM_STEPS + FRAC_W;
  localparam int unsigned STEP_W     = $clog2(STEPS + 1);

  logic                busy_q;
  logic                done_q;
  logic [STEP_W-1:0]   step_q;
  logic [OPER_W-1:0]   x_q;
  logic [EXP_W-1:0]    clz_q;
  logic [MANT_W-1:0]   y_q;
  logic [FRAC_W-1:0]   frac_q;

  logic                     norm_phase;
  logic [STEP_W-1:0]        k_idx;
  logic [EXP_W-1:0]         sh;
  logic [OPER_W-1:0]        top_mask;
  logic                     top_zero;
  logic [OPER_W+MANT_W-1:0] x_ext;
  logic [MANT_W-1:0]        mant;
  logic [MANT_W-1:0]        y_src;
  logic [2*MANT_W-1:0]      y_sq;
  logic [MANT_W:0]          q;
  logic                     grow;
  logic [MANT_W-1:0]        y_next;

  assign norm_phase = step_q < STEP_W'(NORM_STEPS);
  assign k_idx      = STEP_W'(NORM_STEPS - 1) - step_q;
  assign sh         = EXP_W'(1) << k_idx;
  assign top_mask   = ~({OPER_W{1'b1}} >> sh);
  assign top_zero   = (x_q & top_mask) == '0;

  // MSB of the normalized word lands on bit 30 of the Q30 mantissa
  assign x_ext = {x_q, {MANT_W{1'b0}}};
  assign mant  = x_ext[OPER_W+MANT_W-1 -: MANT_W];

  assign y_src  = (step_q == STEP_W'(NORM_STEPS)) ? mant : y_q;
  assign y_sq   = y_src * y_src;
  assign q      = y_sq[2*MANT_W-1:MANT_W-1];
  assign grow   = q[MANT_W];
  assign y_next = grow ? q[MANT_W:1] : q[MANT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= oper_i;
      clz_q <= '0;
    end else if (busy_q) begin
      if (norm_phase) begin
        if (top_zero) begin
          x_q   <= x_q << sh;
          clz_q <= clz_q + sh;
        end
      end else begin
        y_q    <= y_next;
        frac_q <= {frac_q[FRAC_W-2:0], grow};
      end
    end
  end

  assign done_o = done_q;
  assign log_o  = {EXP_W'(OPER_W - 1) - clz_q, frac_q};

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("log2 restarted while busy");

endmodule

FILE: sv/crlvg_datapath.sv
// ----------------------------------------------------------------------------
// crlvg_datapath
// Config registers, square/sum datapath, chunk level conversion, peak hold,
// voice gate and output register.
// ----------------------------------------------------------------------------
module crlvg_datapath import crlvg_pkg::*; #(
  parameter int unsigned CHUNK_SAMPLES = CHUNK_SAMPLES_DEF,
  parameter int unsigned HOLD_MS       = HOLD_MS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic signed [SAMPLE_W-1:0]  sample_i,
  input  logic                        last_in_buffer_i,
  input  logic [TIME_W-1:0]           now_ms_i,
  input  logic [TIME_W-1:0]           talk_until_ms_i,
  input  logic                        encoder_ready_i,
  input  logic                        out_stall_i,
  output logic signed [LEVEL_W-1:0]   level_db_o,
  output logic                        active_o,
  output logic                        out_valid_o,
  input  dp_cmd_t                     cmd_i,
  output dp_status_t                  status_o
);

  localparam int unsigned CNT_W   = $clog2(CHUNK_SAMPLES + 1);
  localparam int unsigned SUM_K   = $clog2(CHUNK_SAMPLES);
  localparam int unsigned USUM_W  = USQ_W + SUM_K;
  localparam int unsigned GSUM_W  = GSQ_W + SUM_K;
  localparam int unsigned EXP_W   = $clog2(GSUM_W);
  localparam int unsigned LOG_W   = EXP_W + FRAC_W;
  localparam int unsigned DIFF_W  = LOG_W + 1;
  localparam int unsigned SCALE_W = DIFF_W + DB_K_W;
  localparam int unsigned MAGR_W  = SCALE_W - ROUND_SHIFT;
  localparam int unsigned RND_W   = MAGR_W + 1;
  localparam int unsigned LVL_W   = RND_W + 1;

  localparam logic signed [DB_K_W-1:0] DB_K       = DB_K_W'(DB_PER_LOG2);
  localparam logic [SCALE_W-1:0]       ROUND_HALF = SCALE_W'(1) << (ROUND_SHIFT - 1);
  localparam logic signed [LVL_W-1:0]  FS_DB      = LVL_W'(FULL_SCALE_DB);

  // config
  logic [GAIN_W-1:0]         gain_q;
  logic signed [LEVEL_W-1:0] thresh_q;
  logic                      vmode_q;

  // captured beat
  logic [MAG_W-1:0]  mag_q;
  logic              last_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] talk_q;
  logic              enc_q;

  logic [USQ_W-1:0]   usq_q;
  logic [GPROD_W-1:0] gprod_q;
  logic [GSQ_W-1:0]   gsq_q;
  logic [USUM_W-1:0]  usum_q;
  logic [GSUM_W-1:0]  gsum_q;
  logic [CNT_W-1:0]   count_q;

  logic [LOG_W-1:0]          ln_q;
  logic signed [SCALE_W-1:0] t_q;
  logic signed [RND_W-1:0]   r_q;
  logic signed [LEVEL_W-1:0] upeak_q;
  logic signed [LEVEL_W-1:0] gpeak_q;
  logic [TIME_W-1:0]         last_loud_q;

  logic                      out_valid_q;
  logic signed [LEVEL_W-1:0] level_q;
  logic                      active_q;

  // ---- per-sample arithmetic
  logic [MAG_W-1:0]          s_ext;
  logic [MAG_W-1:0]          mag_in;
  logic [2*MAG_W-1:0]        usq_full;
  logic [MAG_W+GAIN_W-1:0]   gprod_full;
  logic [GPROD_W-1:0]        g_rnd;
  logic [GMAG_W-1:0]         gmag;
  logic [GSQ_W-1:0]          gsq_full;
  logic [CNT_W-1:0]          cnt_next;

  assign s_ext      = {sample_i[SAMPLE_W-1], sample_i};
  assign mag_in     = s_ext[MAG_W-1] ? (~s_ext + MAG_W'(1)) : s_ext;
  assign usq_full   = mag_q * mag_q;
  assign gprod_full = mag_q * gain_q;
  assign g_rnd      = gprod_q + GPROD_W'(GAIN_HALF);
  assign gmag       = g_rnd[GPROD_W-1:GAIN_SHIFT];
  assign gsq_full   = gmag * gmag;
  assign cnt_next   = count_q + CNT_W'(1);

  // ---- chunk level
  logic [GSUM_W-1:0]         log_oper;
  logic                      log_done;
  logic [LOG_W-1:0]          log_res;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [SCALE_W-1:0] t_full;
  logic [SCALE_W-1:0]        t_abs;
  logic [SCALE_W-1:0]        t_rsum;
  logic [MAGR_W-1:0]         mag_r;
  logic signed [RND_W-1:0]   r_next;
  logic signed [LVL_W-1:0]   lvl;
  logic                      sum_zero;
  logic signed [LEVEL_W-1:0] chunk_db;

  always_comb begin
    unique case (cmd_i.log_sel)
      OP_COUNT:  log_oper = GSUM_W'(count_q);
      OP_UNITY:  log_oper = GSUM_W'(usum_q);
      OP_GAINED: log_oper = gsum_q;
      default:   log_oper = gsum_q;
    endcase
  end

  crlvg_log2 #(
    .OPER_W (GSUM_W)
  ) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.log_start),
    .oper_i  (log_oper),
    .done_o  (log_done),
    .log_o   (log_res)
  );

  assign diff   = $signed({1'b0, log_res}) - $signed({1'b0, ln_q});
  assign t_full = diff * DB_K;

  // round half away from zero
  assign t_abs  = t_q[SCALE_W-1] ? $unsigned(-t_q) : $unsigned(t_q);
  assign t_rsum = t_abs + ROUND_HALF;
  assign mag_r  = t_rsum[SCALE_W-1:ROUND_SHIFT];
  assign r_next = t_q[SCALE_W-1] ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});

  assign lvl      = $signed({r_q[RND_W-1], r_q}) - FS_DB;
  assign sum_zero = (cmd_i.log_sel == OP_GAINED) ? (gsum_q == '0) : (usum_q == '0);

  always_comb begin
    priority if (sum_zero) begin
      chunk_db = FLOOR_DB;
    end else if (lvl > 0) begin
      chunk_db = '0;
    end else if (lvl < FLOOR_DB) begin
      chunk_db = FLOOR_DB;
    end else begin
      chunk_db = lvl[LEVEL_W-1:0];
    end
  end

  // ---- voice gate
  logic              act_base;
  logic              vad_on;
  logic              loud;
  logic [TIME_W-1:0] loud_next;
  logic [TIME_W-1:0] since_loud;
  logic              act_out;

  assign act_base   = enc_q && (vmode_q || (now_q < talk_q));
  assign vad_on     = act_base && vmode_q;
  assign loud       = upeak_q > thresh_q;
  assign loud_next  = (vad_on && loud) ? now_q : last_loud_q;
  assign since_loud = now_q - loud_next;
  assign act_out    = vad_on ? (since_loud < TIME_W'(HOLD_MS)) : act_base;

  // ---- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GAIN_RESET;
      thresh_q <= THRESH_RESET;
      vmode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_INPUT_GAIN:   gain_q   <= cfg_wdata_i;
        CFG_THRESHOLD_DB: thresh_q <= $signed(cfg_wdata_i);
        CFG_VOICE_MODE:   vmode_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mag_q  <= mag_in;
      last_q <= last_in_buffer_i;
      now_q  <= now_ms_i;
      talk_q <= talk_until_ms_i;
      enc_q  <= encoder_ready_i;
    end
    if (cmd_i.square) begin
      usq_q   <= usq_full[USQ_W-1:0];
      gprod_q <= gprod_full[GPROD_W-1:0];
    end
    if (cmd_i.gain_square) begin
      gsq_q <= gsq_full;
    end
    if (cmd_i.latch_ln) begin
      ln_q <= log_res;
    end
    if (cmd_i.scale) begin
      t_q <= t_full;
    end
    if (cmd_i.round) begin
      r_q <= r_next;
    end
    if (cmd_i.emit) begin
      level_q  <= gpeak_q;
      active_q <= act_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usum_q      <= '0;
      gsum_q      <= '0;
      count_q     <= '0;
      upeak_q     <= FLOOR_DB;
      gpeak_q     <= FLOOR_DB;
      last_loud_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accumulate) begin
        usum_q  <= usum_q + USUM_W'(usq_q);
        gsum_q  <= gsum_q + GSUM_W'(gsq_q);
        count_q <= cnt_next;
      end else if (cmd_i.clear_chunk) begin
        usum_q  <= '0;
        gsum_q  <= '0;
        count_q <= '0;
      end

      if (cmd_i.peak_update) begin
        if (cmd_i.log_sel == OP_GAINED) begin
          if (chunk_db > gpeak_q) gpeak_q <= chunk_db;
        end else begin
          if (chunk_db > upeak_q) upeak_q <= chunk_db;
        end
      end else if (cmd_i.emit) begin
        upeak_q     <= FLOOR_DB;
        gpeak_q     <= FLOOR_DB;
        last_loud_q <= loud_next;
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.close_chunk = last_q || (cnt_next >= CNT_W'(CHUNK_SAMPLES));
  assign status_o.buffer_end  = last_q;
  assign status_o.log_done    = log_done;
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  assign level_db_o  = level_q;
  assign active_o    = active_q;
  assign out_valid_o = out_valid_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrote a pending beat");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CHUNK_SAMPLES))
    else $error("chunk count past chunk size");

  a_peak_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gpeak_q <= 0) && (gpeak_q >= FLOOR_DB) && (upeak_q <= 0) && (upeak_q >= FLOOR_DB))
    else $error("peak level out of range");

endmodule

FILE: sv/crlvg_ctrl.sv
// ----------------------------------------------------------------------------
// crlvg_ctrl
// Sequencer: per-sample square/accumulate, then at chunk end three log2 runs,
// scale and peak update, then the buffer-end result.
// ----------------------------------------------------------------------------
module crlvg_ctrl import crlvg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_GSQ,
    S_ACC,
    S_LOGN,
    S_LOGN_W,
    S_LOGS,
    S_LOGS_W,
    S_SCALE,
    S_ROUND,
    S_PEAK,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   gained_q, gained_d;  // second level of the chunk in progress

  always_comb begin
    state_d  = state_q;
    gained_d = gained_q;
    cmd_o    = '0;
    cmd_o.log_sel = gained_q ? OP_GAINED : OP_UNITY;

    unique case (state_q)
      S_IDLE: begin
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) state_d = S_SQ;
      end
      S_SQ: begin
        cmd_o.square = 1'b1;
        state_d      = S_GSQ;
      end
      S_GSQ: begin
        cmd_o.gain_square = 1'b1;
        state_d           = S_ACC;
      end
      S_ACC: begin
        cmd_o.accumulate = 1'b1;
        state_d          = status_i.close_chunk ? S_LOGN : S_IDLE;
      end
      S_LOGN: begin
        cmd_o.log_start = 1'b1;
        cmd_o.log_sel   = OP_COUNT;
        state_d         = S_LOGN_W;
      end
      S_LOGN_W: begin
        cmd_o.log_sel = OP_COUNT;
        if (status_i.log_done) begin
          cmd_o.latch_ln = 1'b1;
          gained_d       = 1'b0;
          state_d        = S_LOGS;
        end
      end
      S_LOGS: begin
        cmd_o.log_start = 1'b1;
        state_d         = S_LOGS_W;
      end
      S_LOGS_W: begin
        if (status_i.log_done) state_d = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = S_PEAK;
      end
      S_PEAK: begin
        cmd_o.peak_update = 1'b1;
        if (!gained_q) begin
          gained_d = 1'b1;
          state_d  = S_LOGS;
        end else begin
          cmd_o.clear_chunk = 1'b1;
          state_d           = status_i.buffer_end ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      gained_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      gained_q <= gained_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.log_done |-> (state_q == S_LOGN_W || state_q == S_LOGS_W))
    else $error("log2 result arrived outside a wait state");

endmodule

FILE: sv/chunked_rms_level_voice_gate_top.sv
// ----------------------------------------------------------------------------
// chunked_rms_level_voice_gate_top
// RMS level meter in dBFS with a voice-activity gate.
//
// Takes one signed 16-bit sample per input beat and sums its square twice,
// at unity gain and at input_gain (Q4.12), over chunks of CHUNK_SAMPLES
// samples; the last chunk of a buffer may be shorter. At each chunk end the
// mean square becomes a Q8.8 dBFS level clamped to -127..0 dB (an all-zero
// chunk reads -127 dB), and the buffer keeps its loudest chunk at both gains.
// On the beat flagged last_in_buffer one result beat follows: the gained peak
// level and an active flag (encoder ready and either voice mode, or now_ms
// before talk_until_ms; in voice mode the unity peak must also have crossed
// threshold_db within the last HOLD_MS ms). After a sample is accepted,
// in_stall_o stays high until it has been squared, gain-squared and
// accumulated. A sample that closes a chunk adds the chunk conversion: three
// runs of the shared log2 unit (sample count, sum at unity gain, sum with
// gain), each $clog2(sum width) leading-zero steps plus 16 mantissa
// squarings, with scale, round and peak update after each sum. A buffer end
// adds the load of the output register, which waits for the previous result
// to be taken. Config writes are meant for idle periods.
// ----------------------------------------------------------------------------
module chunked_rms_level_voice_gate_top import crlvg_pkg::*; #(
  parameter int unsigned CHUNK_SAMPLES = CHUNK_SAMPLES_DEF,  // 1..256
  parameter int unsigned HOLD_MS       = HOLD_MS_DEF         // 1..1000
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  // config write port
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata_i,

  // sample beats
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [SAMPLE_W-1:0]  sample_i,
  input  logic                        last_in_buffer_i,
  input  logic [TIME_W-1:0]           now_ms_i,
  input  logic [TIME_W-1:0]           talk_until_ms_i,
  input  logic                        encoder_ready_i,

  // result beats, one per buffer
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [LEVEL_W-1:0]   level_db_o,
  output logic                        active_o
);

  // Controller and datapath talk only through these two bundles
  dp_cmd_t    cmd;
  dp_status_t status;

  crlvg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Sums, log conversion, peaks, gate and the output register
  crlvg_datapath #(
    .CHUNK_SAMPLES (CHUNK_SAMPLES),
    .HOLD_MS       (HOLD_MS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .sample_i         (sample_i),
    .last_in_buffer_i (last_in_buffer_i),
    .now_ms_i         (now_ms_i),
    .talk_until_ms_i  (talk_until_ms_i),
    .encoder_ready_i  (encoder_ready_i),
    .out_stall_i      (out_stall_i),
    .level_db_o       (level_db_o),
    .active_o         (active_o),
    .out_valid_o      (out_valid_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

endmodule
